// ===== rtl/rrts_pkg.sv =====
// Shared types and constants for the round-robin task scheduler.
// No dependencies; imported by the top level, the slot cells and the checker.
package rrts_pkg;

    localparam int TASK_SLOTS_DEF  = 64;
    localparam int EVENT_SLOTS_DEF = 16;

    localparam logic [7:0]  TS_RESET  = 8'd5;
    localparam logic [15:0] TPM_RESET = 16'd1;
    localparam logic [15:0] EVCNT_MAX = 16'hFFFF;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOSLOT = 2'd1;
    localparam logic [1:0] ST_IDLE   = 2'd2;

    typedef enum logic [3:0] {
        CMD_TICK    = 4'd0,
        CMD_RESCHED = 4'd1,
        CMD_CREATE  = 4'd2,
        CMD_KILL    = 4'd3,
        CMD_PAUSE   = 4'd4,
        CMD_RESUME  = 4'd5,
        CMD_SLEEP   = 4'd6,
        CMD_WAIT    = 4'd7,
        CMD_SIGNAL  = 4'd8
    } t_cmd;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_KILL,
        OP_PAUSE,
        OP_RESUME,
        OP_WAIT,
        OP_CLR_RUN,
        OP_PICK,
        OP_CREATE
    } t_cell_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_SLEEP,
        S_DONE
    } t_state;

    typedef struct packed {
        logic used;
        logic running;
        logic paused;
        logic aborted;
        logic waiting;
    } t_flags;

    // broadcast to every cell of the ring
    typedef struct packed {
        t_cell_op op;
        logic     tok_load;
        logic     tok_shift;
    } t_cell_ctl;

endpackage

// ===== rtl/round_robin_task_scheduler.sv =====
// Round-robin task scheduler: top level with command sequencer, event counters,
// uptime and timeslice. Depends on rrts_pkg, rrts_cell and rrts_ram.
//
// One command is taken at a time. Tick, kill, pause, resume, wait, signal and
// unknown commands go from S_EXEC straight to S_DONE; sleep passes through
// S_SLEEP to write the wake time from the registered ms * ticks_per_ms product.
// Resched and create walk a token around the ring of slot cells, one slot per
// cycle, visiting up to TASK_SLOTS slots before the pick or the end of the sweep.
// The input is ready again once the result is loaded into the output register,
// which waits while a held result is not taken. Wake times live in a RAM read
// one slot ahead of the token.
module round_robin_task_scheduler #(
    parameter int TASK_SLOTS  = rrts_pkg::TASK_SLOTS_DEF,
    parameter int EVENT_SLOTS = rrts_pkg::EVENT_SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // task_index[5:0], task_present[6], sleep_ms[22:7],
                                     // event_index[26:23], zero fill
    input  logic [3:0]  i_s_tuser,   // cmd[3:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [15:0] o_m_tdata,   // status[1:0], chosen_task[7:2], resched_due[8], zero fill
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import rrts_pkg::*;

    localparam int IW = $clog2(TASK_SLOTS);
    localparam int EW = (EVENT_SLOTS > 1) ? $clog2(EVENT_SLOTS) : 1;
    localparam logic [IW-1:0] LAST = IW'(TASK_SLOTS - 1);

    t_state        r_state, n_state;
    t_cmd          r_cmd;
    logic [5:0]    r_idx;
    logic          r_pres;
    logic [15:0]   r_ms;
    logic [EW-1:0] r_ev;
    logic [7:0]    r_ts;
    logic [15:0]   r_tpm;
    logic [63:0]   r_uptime, n_uptime;
    logic [7:0]    r_slice, n_slice;
    logic [15:0]   r_evcnt [EVENT_SLOTS];
    logic [IW-1:0] r_scan_idx, n_scan_idx;
    logic [IW-1:0] r_scan_cnt, n_scan_cnt;
    logic          r_create, n_create;
    logic [31:0]   r_prod, n_prod;
    logic [1:0]    r_status, n_status;
    logic [5:0]    r_chosen, n_chosen;
    logic          r_due, n_due;
    logic          r_m_valid;
    logic [15:0]   r_m_data;

    logic          accept, out_load;
    logic [EW-1:0] ev_mod;
    logic          in_range;
    logic [IW-1:0] idx_n;
    logic [IW-1:0] start;
    logic [8:0]    slice_inc;

    t_cell_ctl     cell_ctl;
    t_flags        w_flags [TASK_SLOTS];
    t_flags        w_hit   [TASK_SLOTS];
    logic [EW-1:0] w_event [TASK_SLOTS];
    logic          w_tok   [TASK_SLOTS];
    t_flags        cur, hit;
    logic [EW-1:0] cur_event;

    logic          ram_we;
    logic [IW-1:0] ram_waddr;
    logic [63:0]   ram_wdata, ram_rdata;

    logic [EW-1:0] ev_raddr;
    logic [15:0]   ev_rdata;
    logic          ev_we;
    logic [15:0]   ev_wdata;
    logic          eligible;

    assign accept      = i_s_tvalid && o_s_tready;
    assign o_s_tready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_m_valid;
    assign o_m_tdata   = r_m_data;

    // event index reduced modulo the counter count, as a small constant table
    always_comb begin
        ev_mod = '0;
        for (int v = 0; v < 16; v++) begin
            if (i_s_tdata[26:23] == 4'(v)) ev_mod = EW'(v % EVENT_SLOTS);
        end
    end

    assign in_range  = (32'(r_idx) < TASK_SLOTS);
    assign idx_n     = IW'(r_idx);
    // create always sweeps from slot 0
    assign start     = (r_cmd == CMD_RESCHED && r_pres && in_range && idx_n != LAST)
                       ? idx_n + 1'b1 : '0;
    assign slice_inc = {1'b0, r_slice} + 9'd1;

    // ring of slot cells
    for (genvar g = 0; g < TASK_SLOTS; g++) begin : g_cell
        rrts_cell #(
            .IW     (IW),
            .EW     (EW),
            .MY_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (cell_ctl),
            .i_idx   (idx_n),
            .i_start (start),
            .i_ev    (r_ev),
            .i_tok   (w_tok[(g + TASK_SLOTS - 1) % TASK_SLOTS]),
            .o_tok   (w_tok[g]),
            .o_flags (w_flags[g]),
            .o_event (w_event[g]),
            .o_hit   (w_hit[g])
        );
    end

    always_comb begin
        cur       = '0;
        hit       = '0;
        cur_event = '0;
        for (int k = 0; k < TASK_SLOTS; k++) begin
            cur       = cur | w_flags[k];
            hit       = hit | w_hit[k];
            cur_event = cur_event | w_event[k];
        end
    end

    rrts_ram #(
        .WIDTH (64),
        .DEPTH (TASK_SLOTS)
    ) u_wake (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (n_scan_idx),
        .o_rdata (ram_rdata)
    );

    assign ev_raddr = (r_state == S_SCAN) ? cur_event : r_ev;
    assign ev_rdata = r_evcnt[ev_raddr];

    assign eligible = cur.used && !cur.running && !cur.paused && (ram_rdata <= r_uptime)
                   && (!cur.waiting || cur.aborted || ev_rdata != '0);

    always_comb begin
        n_state    = r_state;
        n_uptime   = r_uptime;
        n_slice    = r_slice;
        n_scan_idx = r_scan_idx;
        n_scan_cnt = r_scan_cnt;
        n_create   = r_create;
        n_prod     = r_prod;
        n_status   = r_status;
        n_chosen   = r_chosen;
        n_due      = r_due;
        cell_ctl   = '{op: OP_NONE, tok_load: 1'b0, tok_shift: 1'b0};
        ram_we     = 1'b0;
        ram_waddr  = r_scan_idx;
        ram_wdata  = '0;
        ev_we      = 1'b0;
        ev_wdata   = ev_rdata;
        out_load   = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (accept) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_status = ST_OK;
                n_chosen = '0;
                n_due    = 1'b0;
                n_state  = S_DONE;
                case (r_cmd)
                    CMD_TICK: begin
                        n_uptime = r_uptime + 64'd1;
                        if (slice_inc >= {1'b0, r_ts}) begin
                            n_slice = '0;
                            n_due   = 1'b1;
                        end else begin
                            n_slice = slice_inc[7:0];
                        end
                    end
                    CMD_RESCHED: begin
                        if (r_pres && in_range) cell_ctl.op = OP_CLR_RUN;
                        cell_ctl.tok_load = 1'b1;
                        n_scan_idx = start;
                        n_scan_cnt = '0;
                        n_create   = 1'b0;
                        n_state    = S_SCAN;
                    end
                    CMD_CREATE: begin
                        cell_ctl.tok_load = 1'b1;
                        n_scan_idx = '0;
                        n_scan_cnt = '0;
                        n_create   = 1'b1;
                        n_state    = S_SCAN;
                    end
                    CMD_KILL, CMD_PAUSE, CMD_RESUME, CMD_WAIT: begin
                        if (in_range && hit.used) begin
                            case (r_cmd)
                                CMD_KILL:   cell_ctl.op = OP_KILL;
                                CMD_PAUSE:  cell_ctl.op = OP_PAUSE;
                                CMD_RESUME: cell_ctl.op = OP_RESUME;
                                default:    cell_ctl.op = OP_WAIT;
                            endcase
                        end else begin
                            n_status = ST_NOSLOT;
                        end
                    end
                    CMD_SLEEP: begin
                        if (in_range && hit.used) begin
                            n_prod  = r_ms * r_tpm;
                            n_state = S_SLEEP;
                        end else begin
                            n_status = ST_NOSLOT;
                        end
                    end
                    CMD_SIGNAL: begin
                        if (ev_rdata != EVCNT_MAX) begin
                            ev_we    = 1'b1;
                            ev_wdata = ev_rdata + 16'd1;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_SCAN: begin
                if (r_create ? !cur.used : eligible) begin
                    n_status = ST_OK;
                    n_chosen = 6'(r_scan_idx);
                    n_state  = S_DONE;
                    if (r_create) begin
                        cell_ctl.op = OP_CREATE;
                        ram_we      = 1'b1;
                    end else begin
                        cell_ctl.op = OP_PICK;
                        if (cur.waiting && !cur.aborted) begin
                            ev_we    = 1'b1;
                            ev_wdata = ev_rdata - 16'd1;
                        end
                    end
                end else if (r_scan_cnt == LAST) begin
                    n_status = r_create ? ST_NOSLOT : ST_IDLE;
                    n_chosen = '0;
                    n_state  = S_DONE;
                end else begin
                    cell_ctl.tok_shift = 1'b1;
                    n_scan_idx = (r_scan_idx == LAST) ? '0 : r_scan_idx + 1'b1;
                    n_scan_cnt = r_scan_cnt + 1'b1;
                end
            end
            S_SLEEP: begin
                ram_we    = 1'b1;
                ram_waddr = idx_n;
                ram_wdata = r_uptime + {32'd0, r_prod} + 64'd1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_m_valid || i_m_tready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ts      <= TS_RESET;
            r_tpm     <= TPM_RESET;
            r_uptime  <= '0;
            r_slice   <= '0;
            r_m_valid <= 1'b0;
            for (int e = 0; e < EVENT_SLOTS; e++) r_evcnt[e] <= '0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == 1'b0) r_ts  <= i_cfg_data[7:0];
                else                     r_tpm <= i_cfg_data;
            end
            r_uptime <= n_uptime;
            r_slice  <= n_slice;
            if (ev_we) r_evcnt[ev_raddr] <= ev_wdata;
            if (out_load)        r_m_valid <= 1'b1;
            else if (i_m_tready) r_m_valid <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= t_cmd'(i_s_tuser);
            r_idx  <= i_s_tdata[5:0];
            r_pres <= i_s_tdata[6];
            r_ms   <= i_s_tdata[22:7];
            r_ev   <= ev_mod;
        end
        r_scan_idx <= n_scan_idx;
        r_scan_cnt <= n_scan_cnt;
        r_create   <= n_create;
        r_prod     <= n_prod;
        r_status   <= n_status;
        r_chosen   <= n_chosen;
        r_due      <= n_due;
        if (out_load) r_m_data <= {7'd0, r_due, r_chosen, r_status};
    end
endmodule

// ===== rtl/rrts_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rrts_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/rrts_cell.sv =====
// One task slot of the scheduler ring: slot marks, event index and scan token.
// Depends on rrts_pkg.
module rrts_cell #(
    parameter int IW     = 6,
    parameter int EW     = 4,
    parameter int MY_IDX = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  rrts_pkg::t_cell_ctl i_ctl,
    input  logic [IW-1:0]       i_idx,
    input  logic [IW-1:0]       i_start,
    input  logic [EW-1:0]       i_ev,
    input  logic                i_tok,
    output logic                o_tok,
    output rrts_pkg::t_flags    o_flags,
    output logic [EW-1:0]       o_event,
    output rrts_pkg::t_flags    o_hit
);
    import rrts_pkg::*;

    t_flags        r_flags;
    logic [EW-1:0] r_event;
    logic          r_tok;
    logic          sel;

    assign sel = (i_idx == IW'(MY_IDX));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flags <= '0;
            r_tok   <= 1'b0;
        end else begin
            if (i_ctl.tok_load) begin
                r_tok <= (i_start == IW'(MY_IDX));
            end else if (i_ctl.tok_shift) begin
                r_tok <= i_tok;
            end
            case (i_ctl.op)
                OP_KILL: begin
                    if (sel) r_flags <= '0;
                end
                OP_PAUSE: begin
                    if (sel) begin
                        r_flags.paused  <= 1'b1;
                        r_flags.aborted <= 1'b1;
                    end
                end
                OP_RESUME: begin
                    if (sel) begin
                        r_flags.paused  <= 1'b0;
                        r_flags.aborted <= 1'b0;
                    end
                end
                OP_WAIT: begin
                    if (sel) r_flags.waiting <= 1'b1;
                end
                OP_CLR_RUN: begin
                    if (sel) r_flags.running <= 1'b0;
                end
                OP_PICK: begin
                    if (r_tok) begin
                        r_flags.running <= 1'b1;
                        if (r_flags.waiting && !r_flags.aborted) r_flags.waiting <= 1'b0;
                    end
                end
                OP_CREATE: begin
                    if (r_tok) begin
                        r_flags <= '{used: 1'b1, default: 1'b0};
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.op == OP_WAIT && sel) begin
            r_event <= i_ev;
        end
    end

    assign o_tok   = r_tok;
    assign o_flags = r_tok ? r_flags : '0;
    assign o_event = r_tok ? r_event : '0;
    assign o_hit   = sel ? r_flags : '0;
endmodule

// ===== rtl/rrts_checker.sv =====
// Port-level checks for the round-robin task scheduler, bound to the top level.
// Depends on rrts_pkg and round_robin_task_scheduler.
module rrts_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [15:0] o_m_tdata
);
    import rrts_pkg::*;

    a_rst_quiet: assert property (@(posedge i_clk) !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("stalled result changed");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> o_m_tdata[1:0] != 2'd3)
        else $error("undefined status code");

    a_fail_no_task: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[1:0] != ST_OK |-> o_m_tdata[8:2] == 7'd0)
        else $error("failed transaction carries a task or reschedule flag");

    a_due_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tdata[8] |-> o_m_tdata[7:0] == 8'd0)
        else $error("reschedule flag with a slot or status");
endmodule

bind round_robin_task_scheduler rrts_checker u_rrts_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

// ===== tb/round_robin_task_scheduler_test.sv =====
// Self-checking testbench for the round-robin task scheduler.
// Needs only rrts_pkg and the scheduler RTL. Commands are driven on the input stream,
// a built-in scheduler model predicts each reply, and a monitor compares replies in order.
`timescale 1ns / 1ps

module round_robin_task_scheduler_test;
    import rrts_pkg::*;

    localparam int NSLOT = 64;
    localparam int NEV   = 16;
    localparam int DRAIN = 80;          // covers the longest command, a full sweep of the ring, plus margin

    typedef struct packed {
        logic [1:0] status;
        logic [5:0] chosen;
        logic       due;
    } t_reply;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic [31:0] i_s_tdata = '0;
    logic [3:0]  i_s_tuser = '0;
    logic        i_m_tready = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        i_cfg_index = 1'b0;
    logic [15:0] i_cfg_data = '0;
    logic        o_s_tready, o_m_tvalid, o_cfg_ready;
    logic [15:0] o_m_tdata;

    round_robin_task_scheduler u_dut (.*);

    always #4 i_clk = ~i_clk;

    // scheduler model state
    logic        used_q [NSLOT];
    logic        run_q  [NSLOT];
    logic        pause_q[NSLOT];
    logic        abort_q[NSLOT];
    logic        wait_q [NSLOT];
    logic [3:0]  evsel_q[NSLOT];
    logic [63:0] wake_q [NSLOT];
    logic [15:0] evcnt_q[NEV];
    logic [63:0] uptime_q;
    logic [7:0]  slice_q;
    logic [7:0]  timeslice_q;
    logic [15:0] tpm_q;

    t_reply replies_due[$];
    int     n_sent, n_checked, n_mismatch, n_idle_picks, n_full;
    bit     idle_on = 1'b1;

    function automatic bit pick_ok(int s);
        if (!used_q[s] || run_q[s] || pause_q[s]) return 1'b0;
        if (wake_q[s] > uptime_q) return 1'b0;
        if (wait_q[s] && !abort_q[s]) begin
            if (evcnt_q[evsel_q[s]] == 16'd0) return 1'b0;
            evcnt_q[evsel_q[s]]--;
            wait_q[s] = 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic t_reply sched_predict(logic [3:0] cmd, logic [5:0] idx, logic present,
                                             logic [15:0] ms, logic [3:0] ev);
        t_reply r;
        int     start, s;
        logic [8:0] nxt;
        r = '0;
        case (cmd)
            CMD_TICK: begin
                nxt = slice_q + 9'd1;
                uptime_q++;
                if (nxt >= {1'b0, timeslice_q}) begin
                    slice_q = '0;
                    r.due = 1'b1;
                end else begin
                    slice_q = nxt[7:0];
                end
            end
            CMD_RESCHED: begin
                start = 0;
                if (present) begin
                    run_q[idx] = 1'b0;
                    start = (idx + 1) % NSLOT;
                end
                r.status = ST_IDLE;
                for (int i = 0; i < NSLOT; i++) begin
                    s = (start + i) % NSLOT;
                    if (pick_ok(s)) begin
                        run_q[s] = 1'b1;
                        r.status = ST_OK;
                        r.chosen = s[5:0];
                        break;
                    end
                end
                if (r.status == ST_IDLE) n_idle_picks++;
            end
            CMD_CREATE: begin
                r.status = ST_NOSLOT;
                for (int i = 0; i < NSLOT; i++) begin
                    if (!used_q[i]) begin
                        used_q[i] = 1'b1; run_q[i] = 1'b0; pause_q[i] = 1'b0;
                        abort_q[i] = 1'b0; wait_q[i] = 1'b0; evsel_q[i] = '0;
                        wake_q[i] = '0;
                        r.status = ST_OK;
                        r.chosen = i[5:0];
                        break;
                    end
                end
                if (r.status == ST_NOSLOT) n_full++;
            end
            CMD_KILL, CMD_PAUSE, CMD_RESUME, CMD_SLEEP, CMD_WAIT: begin
                if (!used_q[idx]) begin
                    r.status = ST_NOSLOT;
                end else begin
                    case (cmd)
                        CMD_KILL: begin
                            used_q[idx] = 1'b0; run_q[idx] = 1'b0; pause_q[idx] = 1'b0;
                            abort_q[idx] = 1'b0; wait_q[idx] = 1'b0;
                        end
                        CMD_PAUSE:  begin abort_q[idx] = 1'b1; pause_q[idx] = 1'b1; end
                        CMD_RESUME: begin abort_q[idx] = 1'b0; pause_q[idx] = 1'b0; end
                        CMD_SLEEP:  wake_q[idx] = uptime_q + 64'(ms) * 64'(tpm_q) + 64'd1;
                        default:    begin wait_q[idx] = 1'b1; evsel_q[idx] = ev; end
                    endcase
                end
            end
            CMD_SIGNAL: if (evcnt_q[ev] != EVCNT_MAX) evcnt_q[ev]++;
            default: ;
        endcase
        if (r.status != ST_OK) r.chosen = '0;
        return r;
    endfunction

    task automatic send_cmd(logic [3:0] cmd, logic [5:0] idx = 0, logic present = 0,
                            logic [15:0] ms = 0, logic [3:0] ev = 0);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {5'b0, ev, ms, present, idx};
        i_s_tuser  <= cmd;
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        replies_due.push_back(sched_predict(cmd, idx, present, ms, ev));
        n_sent++;
    endtask

    task automatic wait_quiet();
        i_s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (replies_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_reg(logic index, logic [15:0] value);
        wait_quiet();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        if (index == 1'b0) timeslice_q = value[7:0];
        else               tpm_q = value;
    endtask

    // reply monitor and receiver stalls
    int stall_left = 0;
    always @(posedge i_clk) begin
        t_reply got, want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            got = '{status: o_m_tdata[1:0], chosen: o_m_tdata[7:2], due: o_m_tdata[8]};
            n_checked++;
            if (replies_due.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected reply %h", o_m_tdata);
            end else begin
                want = replies_due.pop_front();
                if (got !== want || o_m_tdata[15:9] !== 7'd0) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display({"reply %0d: expected st=%0d task=%0d due=%0d, ",
                                  "got st=%0d task=%0d due=%0d"},
                                 n_checked, want.status, want.chosen, want.due,
                                 got.status, got.chosen, got.due);
                end
            end
        end
        if (stall_left > 0) begin
            stall_left--;
            i_m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 17);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    task automatic test_directed();
        send_cmd(CMD_RESCHED);                          // empty table: idle
        send_cmd(CMD_KILL, 6'd63);                      // empty slot
        send_cmd(CMD_PAUSE, 6'd0);
        send_cmd(CMD_CREATE);
        send_cmd(CMD_CREATE);
        send_cmd(CMD_CREATE);
        send_cmd(CMD_RESCHED, 6'd63, 1'b1);             // wraps to slot 0
        send_cmd(CMD_RESCHED, 6'd0, 1'b1);
        send_cmd(CMD_WAIT, 6'd2, 0, 0, 4'd15);
        send_cmd(CMD_RESCHED, 6'd1, 1'b1);              // slot 2 blocked on event
        send_cmd(CMD_SIGNAL, 0, 0, 0, 4'd15);
        send_cmd(CMD_RESCHED, 6'd0, 1'b1);              // picks slot 1, the event stays pending
        send_cmd(CMD_SLEEP, 6'd1, 0, 16'hFFFF);
        send_cmd(CMD_PAUSE, 6'd0);
        send_cmd(CMD_WAIT, 6'd0, 0, 0, 4'd3);
        send_cmd(CMD_RESCHED, 6'd2, 1'b1);
        send_cmd(CMD_RESUME, 6'd0);                     // waits again, not aborted
        send_cmd(CMD_PAUSE, 6'd0);                      // aborted waiter is still paused
        send_cmd(CMD_RESCHED, 6'd2, 1'b1);
        repeat (6) send_cmd(CMD_TICK);
        send_cmd(CMD_KILL, 6'd1);
        send_cmd(4'd15, 6'h3F, 1'b1, 16'hFFFF, 4'hF);   // unknown command
        send_cmd(4'd9);
    endtask

    task automatic test_config_extremes();
        write_reg(1'b0, 16'd1);
        write_reg(1'b1, 16'd65535);
        repeat (3) send_cmd(CMD_TICK);
        send_cmd(CMD_SLEEP, 6'd0, 0, 16'd1);
        send_cmd(CMD_RESCHED);
        write_reg(1'b0, 16'd0);                         // zero asks for a resched every tick
        write_reg(1'b1, 16'd0);
        repeat (2) send_cmd(CMD_TICK);
        send_cmd(CMD_SLEEP, 6'd0, 0, 16'd40000);
        send_cmd(CMD_RESCHED);
        write_reg(1'b0, 16'd255);
        write_reg(1'b1, 16'd1);
        repeat (4) send_cmd(CMD_TICK);
    endtask

    task automatic test_table_full();
        repeat (NSLOT + 2) send_cmd(CMD_CREATE);
        repeat (70) send_cmd(CMD_RESCHED, 6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
        for (int i = 0; i < NSLOT; i += 2) send_cmd(CMD_KILL, i[5:0]);
    endtask

    task automatic random_item(bit busy_mix);
        logic [3:0]  cmd;
        logic [5:0]  idx;
        logic [15:0] ms;
        int          w;
        w = $urandom_range(0, 99);
        if      (w < 14) cmd = CMD_CREATE;
        else if (w < 36) cmd = CMD_RESCHED;
        else if (w < 52) cmd = CMD_TICK;
        else if (w < 59) cmd = CMD_KILL;
        else if (w < 65) cmd = CMD_PAUSE;
        else if (w < 71) cmd = CMD_RESUME;
        else if (w < 78) cmd = CMD_SLEEP;
        else if (w < 86) cmd = CMD_WAIT;
        else if (w < 98) cmd = CMD_SIGNAL;
        else             cmd = 4'($urandom_range(9, 15));
        idx = ($urandom_range(0, 9) == 0 || !busy_mix) ? 6'($urandom) : 6'($urandom_range(0, 11));
        ms  = ($urandom_range(0, 19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
        send_cmd(cmd, idx, 1'($urandom_range(0, 1)), ms, 4'($urandom));
    endtask

    task automatic test_random_mix();
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(1'b0, 16'($urandom_range(1, 8)));
            write_reg(1'b1, 16'($urandom_range(1, 3)));
            for (int i = 0; i < 450; i++) random_item(ph != 3);
        end
        wait_quiet();
        idle_on = 1'b0;                                 // back-to-back tail
        for (int i = 0; i < 200; i++) random_item(1'b1);
    endtask

    initial begin
        for (int i = 0; i < NSLOT; i++) begin
            used_q[i] = 0; run_q[i] = 0; pause_q[i] = 0; abort_q[i] = 0; wait_q[i] = 0;
            evsel_q[i] = '0; wake_q[i] = '0;
        end
        for (int e = 0; e < NEV; e++) evcnt_q[e] = '0;
        uptime_q = '0; slice_q = '0; timeslice_q = TS_RESET; tpm_q = TPM_RESET;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_config_extremes();
        test_table_full();
        test_random_mix();
        wait_quiet();
        $display("Ran %0d commands, checked %0d replies (%0d idle picks, %0d full creates),",
                 n_sent, n_checked, n_idle_picks, n_full);
        $display("over timeslice and tick-rate settings including 0, 1 and the maximum.");
        if (n_mismatch == 0 && replies_due.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("%0d mismatches, %0d replies missing", n_mismatch, replies_due.size());
            $display("Simulation FAILED");
        end
        $finish;
    end

    initial begin
        #20ms;
        $display("timeout");
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/rrts_pkg.sv
rtl/rrts_ram.sv
rtl/rrts_cell.sv
rtl/round_robin_task_scheduler.sv
rtl/rrts_checker.sv
tb/round_robin_task_scheduler_test.sv
